FILE: hdl/bse_pkg.sv
// Shared types and constants for the byte entropy block.
package bse_pkg;

  localparam int unsigned NUM_BINS  = 256;
  localparam int unsigned BIN_W     = 8;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned LOG_FRAC  = 24;
  localparam int unsigned LOG_W     = 4 + LOG_FRAC;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned ENT_W     = 20;
  localparam logic [CNT_W-1:0] MAX_BYTES = 11'd1024;
  localparam logic [ACC_W-1:0] ENT_MAX   = 40'd524288;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INC, S_FIN, S_RD, S_RDW, S_LOGW, S_ACC,
    S_NLOG, S_NWAIT, S_DIVSET, S_DIV, S_SAT, S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] x;
  } log_req_t;

endpackage

FILE: hdl/bse_log.sv
// Iterative log2 unit: integer part from the leading one, fraction by repeated squaring.
module bse_log (
  input  logic                       clk,
  input  logic                       rst,
  input  bse_pkg::log_req_t          req,
  output logic                       done,
  output logic [bse_pkg::LOG_W-1:0]  result
);

  logic                          run;
  logic [4:0]                    cnt;
  logic [31:0]                   m;
  logic [3:0]                    e;
  logic [bse_pkg::LOG_FRAC-1:0]  frac;
  logic [3:0]                    e_new;
  logic [31:0]                   m_new;
  logic [63:0]                   prod;
  logic [32:0]                   sq;

  always_comb begin
    e_new = 4'd0;
    for (int i = 0; i < bse_pkg::CNT_W; i++) begin
      if (req.x[i]) e_new = 4'(i);
    end
    m_new = 32'(req.x) << (5'd31 - 5'(e_new));
  end

  assign prod   = 64'(m) * 64'(m);
  assign sq     = prod[63:31];
  assign result = {e, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        cnt  <= 5'(bse_pkg::LOG_FRAC);
        m    <= m_new;
        e    <= e_new;
        frac <= '0;
      end else if (run) begin
        // A square at or above two yields a one bit and renormalizes.
        frac <= {frac[bse_pkg::LOG_FRAC-2:0], sq[32]};
        m    <= sq[32] ? sq[32:1] : sq[31:0];
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/byte_shannon_entropy.sv
// Top level: byte histogram and sequenced Shannon entropy computation.
// Usage: drive data_byte and last_byte with start high; the beat is taken at
// an edge where busy is low. Each byte occupies the block while its
// histogram bin is read and written back. Bytes beyond 1024 per buffer
// are dropped and reported through overflowed.
// On the beat with last_byte set, a final pass walks all 256 bins after a
// setup state; each occupied bin waits on the shared 24-step squaring log2
// unit. Then come log2 of the total, the bit-serial restoring divider and
// the states that saturate and show the result. The pass clears each bin
// as it goes.
// The result appears for one cycle with done high:
// entropy_bits (16 fraction bits), byte_total and overflowed. The receiver
// cannot stall; a result must be taken in the cycle it is shown.
// After reset the block stays busy while it zeroes the histogram memory.
module byte_shannon_entropy (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        done,
  output logic [19:0] entropy_bits,
  output logic [10:0] byte_total,
  output logic        overflowed
);

  localparam int unsigned CW = bse_pkg::CNT_W;
  localparam int unsigned AW = bse_pkg::ACC_W;

  bse_pkg::state_t state, state_next;

  logic [CW-1:0]            mem [bse_pkg::NUM_BINS];
  logic [CW-1:0]            rd_data;
  logic [bse_pkg::BIN_W-1:0] rd_addr, wr_addr;
  logic [CW-1:0]            wr_data;
  logic                     wr_en;

  logic [bse_pkg::BIN_W-1:0] byte_reg;
  logic                     last_reg;
  logic [bse_pkg::BIN_W-1:0] bin;
  logic [CW-1:0]            bytes_seen;
  logic                     overflow_seen;
  logic [CW-1:0]            c_reg;
  logic [AW-1:0]            prod_reg;
  logic [AW-1:0]            acc;
  logic [AW-1:0]            whole;
  logic [AW-1:0]            num;
  logic [18:0]              rem;
  logic [5:0]               div_cnt;

  bse_pkg::log_req_t           log_req;
  logic                        log_done;
  logic [bse_pkg::LOG_W-1:0]   log_res;

  logic [18:0] divisor;
  logic [19:0] rem_sh;
  logic [19:0] rem_diff;

  bse_log u_log (
    .clk    (clk),
    .rst    (rst),
    .req    (log_req),
    .done   (log_done),
    .result (log_res)
  );

  assign divisor  = {bytes_seen, 8'd0};
  assign rem_sh   = {rem, num[AW-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bse_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b1;
    done        = 1'b0;
    rd_addr     = bin;
    wr_addr     = bin;
    wr_data     = '0;
    wr_en       = 1'b0;
    log_req     = '0;
    case (state)
      bse_pkg::S_CLEAR: begin
        wr_en = 1'b1;
        if (bin == 8'hFF) state_next = bse_pkg::S_IDLE;
      end
      bse_pkg::S_IDLE: begin
        busy    = 1'b0;
        rd_addr = data_byte;
        if (start) state_next = bse_pkg::S_INC;
      end
      bse_pkg::S_INC: begin
        wr_addr = byte_reg;
        wr_data = rd_data + 11'd1;
        wr_en   = (bytes_seen != bse_pkg::MAX_BYTES);
        state_next = last_reg ? bse_pkg::S_FIN : bse_pkg::S_IDLE;
      end
      bse_pkg::S_FIN: begin
        state_next = (bytes_seen == '0) ? bse_pkg::S_OUT : bse_pkg::S_RD;
      end
      bse_pkg::S_RD: state_next = bse_pkg::S_RDW;
      bse_pkg::S_RDW: begin
        wr_en = 1'b1;
        if (rd_data != '0) begin
          log_req.start = 1'b1;
          log_req.x     = rd_data;
          state_next    = bse_pkg::S_LOGW;
        end else begin
          state_next = (bin == 8'hFF) ? bse_pkg::S_NLOG : bse_pkg::S_RD;
        end
      end
      bse_pkg::S_LOGW: if (log_done) state_next = bse_pkg::S_ACC;
      bse_pkg::S_ACC: begin
        state_next = (bin == 8'hFF) ? bse_pkg::S_NLOG : bse_pkg::S_RD;
      end
      bse_pkg::S_NLOG: begin
        log_req.start = 1'b1;
        log_req.x     = bytes_seen;
        state_next    = bse_pkg::S_NWAIT;
      end
      bse_pkg::S_NWAIT: if (log_done) state_next = bse_pkg::S_DIVSET;
      bse_pkg::S_DIVSET: state_next = bse_pkg::S_DIV;
      bse_pkg::S_DIV: if (div_cnt == 6'd1) state_next = bse_pkg::S_SAT;
      bse_pkg::S_SAT: state_next = bse_pkg::S_OUT;
      bse_pkg::S_OUT: begin
        done       = 1'b1;
        state_next = bse_pkg::S_IDLE;
      end
      default: state_next = bse_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin           <= '0;
      bytes_seen    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      case (state)
        bse_pkg::S_CLEAR: bin <= bin + 8'd1;
        bse_pkg::S_IDLE: begin
          byte_reg <= data_byte;
          last_reg <= last_byte;
        end
        bse_pkg::S_INC: begin
          if (bytes_seen != bse_pkg::MAX_BYTES) bytes_seen <= bytes_seen + 11'd1;
          else overflow_seen <= 1'b1;
        end
        bse_pkg::S_FIN: begin
          bin          <= '0;
          acc          <= '0;
          entropy_bits <= '0;
        end
        bse_pkg::S_RDW: begin
          c_reg <= rd_data;
          if (rd_data == '0) bin <= bin + 8'd1;
        end
        bse_pkg::S_LOGW: if (log_done) prod_reg <= AW'(c_reg) * AW'(log_res);
        bse_pkg::S_ACC: begin
          acc <= acc + prod_reg;
          bin <= bin + 8'd1;
        end
        bse_pkg::S_NWAIT: if (log_done) whole <= AW'(bytes_seen) * AW'(log_res);
        bse_pkg::S_DIVSET: begin
          // Negative differences clamp to zero; add half the divisor to round.
          num     <= ((whole > acc) ? (whole - acc) : '0) + AW'({bytes_seen, 7'd0});
          rem     <= '0;
          div_cnt <= 6'(AW);
        end
        bse_pkg::S_DIV: begin
          if (!rem_diff[19]) begin
            rem <= rem_diff[18:0];
            num <= {num[AW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[18:0];
            num <= {num[AW-2:0], 1'b0};
          end
          div_cnt <= div_cnt - 6'd1;
        end
        bse_pkg::S_SAT: begin
          entropy_bits <= (num > bse_pkg::ENT_MAX) ? bse_pkg::ENT_MAX[19:0] : num[19:0];
        end
        bse_pkg::S_OUT: begin
          bytes_seen    <= '0;
          overflow_seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign byte_total = bytes_seen;
  assign overflowed = overflow_seen;

endmodule

FILE: hdl/bse_check.sv
// Port-level checker for the byte entropy block, bound to the top level.
module bse_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [19:0] entropy_bits,
  input logic [10:0] byte_total
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while idle");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result held longer than one beat");
  a_ent_range: assert property (@(posedge clk) disable iff (rst)
    done |-> entropy_bits <= 20'd524288)
    else $error("entropy above eight bits per byte");
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    done |-> byte_total <= 11'd1024)
    else $error("byte total above capacity");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("no busy after an accepted beat");

endmodule

bind byte_shannon_entropy bse_check u_bse_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .entropy_bits (entropy_bits),
  .byte_total   (byte_total)
);

FILE: dv/tb_byte_shannon_entropy.sv
// Self-checking testbench for the byte Shannon entropy block.
module tb_byte_shannon_entropy;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic        chk;
    logic [19:0] ent;
    logic [10:0] tot;
    logic        ovf;
  } stim_row_t;

  typedef struct {
    logic [19:0] ent;
    logic [10:0] tot;
    logic        ovf;
  } entropy_result_t;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned N_ITEMS  = 1700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        busy, done, overflowed;
  logic [19:0] entropy_bits;
  logic [10:0] byte_total;

  int unsigned     hist [bse_pkg::NUM_BINS];
  int unsigned     n_seen;
  bit              ovf_seen;
  entropy_result_t expected_q [$];
  stim_row_t       rows [$];
  bit              failed = 1'b0;

  byte_shannon_entropy DUT (.*);

  always #2 clk = ~clk;

  // log2 with 24 fraction bits by repeated squaring of the mantissa.
  function automatic longint unsigned log2_q24(int unsigned x);
    int e;
    longint unsigned m, frac;
    frac = 0;
    if (x == 0) return 0;
    e = 31;
    while (((x >> e) & 1) == 0) e--;
    m = longint'(x) << (31 - e);
    for (int i = 0; i < bse_pkg::LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    return (longint'(e) << bse_pkg::LOG_FRAC) | frac;
  endfunction

  function automatic logic [19:0] histogram_entropy();
    longint unsigned whole, parts, t, q;
    parts = 0;
    if (n_seen == 0) return '0;
    foreach (hist[i]) if (hist[i] != 0) parts += hist[i] * log2_q24(hist[i]);
    whole = n_seen * log2_q24(n_seen);
    t = (whole > parts) ? whole - parts : 0;
    q = (t + n_seen * 128) / (n_seen * 256);
    if (q > 524288) q = 524288;
    return q[19:0];
  endfunction

  function automatic entropy_result_t count_byte(logic [7:0] b, logic last, output bit emits);
    entropy_result_t r;
    if (n_seen < CAPACITY) begin
      hist[b]++;
      n_seen++;
    end else begin
      ovf_seen = 1'b1;
    end
    emits = last;
    r = '{default: '0};
    if (last) begin
      r.ent = histogram_entropy();
      r.tot = n_seen[10:0];
      r.ovf = ovf_seen;
      foreach (hist[i]) hist[i] = 0;
      n_seen = 0;
      ovf_seen = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_row(logic [7:0] d, logic l, logic c = 0,
                                  logic [19:0] e = 0, logic [10:0] t = 0, logic o = 0);
    rows.push_back('{d, l, c, e, t, o});
  endfunction

  // Buffer of the given length, bytes drawn from span values above a random base.
  function automatic void add_buffer(int unsigned len, int unsigned span);
    logic [7:0] base;
    base = $urandom;
    for (int unsigned i = 0; i < len; i++)
      add_row(base + 8'($urandom_range(span - 1)), i == len - 1);
  endfunction

  // Result checker: a result is shown for one cycle only.
  always @(posedge clk) begin
    entropy_result_t x;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: entropy_bits=%0d byte_total=%0d", entropy_bits, byte_total);
        failed = 1'b1;
      end else begin
        x = expected_q.pop_front();
        if (entropy_bits !== x.ent) begin
          $error("entropy_bits expected %0d got %0d", x.ent, entropy_bits);
          failed = 1'b1;
        end
        if (byte_total !== x.tot) begin
          $error("byte_total expected %0d got %0d", x.tot, byte_total);
          failed = 1'b1;
        end
        if (overflowed !== x.ovf) begin
          $error("overflowed expected %0d got %0d", x.ovf, overflowed);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    entropy_result_t r;
    bit emits;
    int unsigned gap, burst, wait_cnt, len;
    foreach (hist[i]) hist[i] = 0;
    n_seen = 0;
    ovf_seen = 1'b0;

    // Directed: empty-ish and single-valued buffers, extremes, two-value split.
    add_row(8'h00, 1'b1, 1'b1, 20'd0, 11'd1, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b1, 1'b1, 20'd0, 11'd2, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b1, 1'b1, 20'd65536, 11'd2, 1'b0);
    for (int i = 0; i < 4; i++) add_row(8'(1 << i), i == 3, 1'b1, 20'd131072, 11'd4, 1'b0);
    for (int i = 0; i < 8; i++) add_row(8'(1 << i), i == 7);
    add_row(8'h55, 1'b0);
    add_row(8'hAA, 1'b0);
    add_row(8'h55, 1'b1);
    // Full 256 distinct values reach 8.0 bits; one more buffer overflows.
    for (int i = 0; i < 256; i++) add_row(8'(i), i == 255);
    for (int i = 0; i < CAPACITY + 3; i++)
      add_row(8'(i), i == CAPACITY + 2, i == CAPACITY + 2, 20'd524288, 11'd1024, 1'b1);

    // Random part: mostly short buffers, a few longer ones.
    while (rows.size() < N_ITEMS) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(300, 100) : $urandom_range(30, 1);
      if (rows.size() + len > N_ITEMS) len = N_ITEMS - rows.size();
      add_buffer(len, $urandom_range(256, 1));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    burst = 0;
    foreach (rows[k]) begin
      if (burst == 0) begin
        burst = $urandom_range(12, 1);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        if (gap != 0) begin
          @(posedge clk);
          start <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end
      end
      burst--;
      @(posedge clk);
      start <= 1'b1;
      data_byte <= rows[k].data;
      last_byte <= rows[k].last;
      @(posedge clk);
      while (busy) @(posedge clk);
      // The beat is taken at this edge; predict it before anything moves.
      r = count_byte(rows[k].data, rows[k].last, emits);
      if (emits) begin
        if (rows[k].chk && (r.ent !== rows[k].ent || r.tot !== rows[k].tot ||
                            r.ovf !== rows[k].ovf)) begin
          $error("table entry %0d disagrees with prediction", k);
          failed = 1'b1;
        end
        expected_q.push_back(r);
      end
      start <= 1'b0;
    end

    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    if (!failed && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
